// File: rtl/eic_pkg.sv
// Package for the external interrupt controller: codes, item types and lane control types.
`timescale 1ns / 1ps

package eic_pkg;

  localparam int WORD_W = 16;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SEL_STATUS   = 2'd0,
    SEL_MASK     = 2'd1,
    SEL_POLARITY = 2'd2,
    SEL_TYPE     = 2'd3
  } sel_t;

  typedef enum logic {
    CFG_LINE_PRESENT     = 1'b0,
    CFG_LEVEL_HIGH_ONLY  = 1'b1
  } cfg_idx_t;

  localparam logic [WORD_W-1:0] PRESENT_RESET    = 16'hDEF8;
  localparam logic [WORD_W-1:0] HIGH_ONLY_RESET  = 16'hD000;

  typedef struct packed {
    logic [1:0]        op;
    logic [1:0]        reg_sel;
    logic [WORD_W-1:0] write_data;
    logic [WORD_W-1:0] pin_levels;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              irq_request_n;
  } out_item_t;

  typedef struct packed {
    logic tick;
    logic wr_status;
    logic wr_mask;
    logic wr_polarity;
    logic wr_type;
  } lane_ctrl_t;

  typedef struct packed {
    logic pending;
    logic enable;
    logic polarity;
    logic edge_mode;
    logic pending_nxt;
    logic enable_nxt;
  } lane_stat_t;

endpackage

// File: rtl/external_interrupt_controller.sv
// Top level of the external interrupt controller: lanes, merge and output register.
//
// Usage:
//   Input channel in_valid/in_stall/in_item carries one bus operation per item:
//   a tick that samples the pins, a register read or a register write
//   (pending status with write-one-to-clear, mask, polarity, detect type).
//   Output channel out_valid/out_stall/out_item returns one item per input item:
//   the read data (zero unless a read) and the active-low request after the
//   update that the item made.
//   out_valid rises in the cycle after acceptance. Throughput is one item
//   per cycle while the receiver does not stall; one lane per line updates all
//   lines in the same cycle and the merge stage feeds a single output register.
//   While the receiver stalls and a result is held, in_stall is high and the
//   held item stays unchanged; a new item is taken in the cycle the held one
//   leaves.
//   cfg_we/cfg_index/cfg_wdata write the line-present and level-high-only
//   masks; the user must write them only while the block is idle, as the block itself does not enforce this.
//   Synchronous reset clears all line state, empties the output register and
//   restores the configuration masks to their reset values.
`timescale 1ns / 1ps

module external_interrupt_controller #(
  parameter int LINE_COUNT = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  eic_pkg::in_item_t            in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output eic_pkg::out_item_t           out_item,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [eic_pkg::WORD_W-1:0]   cfg_wdata
);

  localparam int LANES = (LINE_COUNT < eic_pkg::WORD_W) ? LINE_COUNT : eic_pkg::WORD_W;

  logic [eic_pkg::WORD_W-1:0] present_r, present_nxt;
  logic [eic_pkg::WORD_W-1:0] high_only_r, high_only_nxt;
  logic                       out_valid_r, out_valid_nxt;
  eic_pkg::out_item_t         out_item_r;
  eic_pkg::out_item_t         merged;
  logic                       in_fire;
  eic_pkg::lane_ctrl_t        ctrl;
  eic_pkg::lane_stat_t        lane_stat [LANES];

  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  always_comb begin
    ctrl = '0;
    if (in_fire) begin
      ctrl.tick = (eic_pkg::op_t'(in_item.op) == eic_pkg::OP_TICK);
      if (eic_pkg::op_t'(in_item.op) == eic_pkg::OP_WRITE) begin
        ctrl.wr_status   = (eic_pkg::sel_t'(in_item.reg_sel) == eic_pkg::SEL_STATUS);
        ctrl.wr_mask     = (eic_pkg::sel_t'(in_item.reg_sel) == eic_pkg::SEL_MASK);
        ctrl.wr_polarity = (eic_pkg::sel_t'(in_item.reg_sel) == eic_pkg::SEL_POLARITY);
        ctrl.wr_type     = (eic_pkg::sel_t'(in_item.reg_sel) == eic_pkg::SEL_TYPE);
      end
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    eic_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .write_bit (in_item.write_data[g]),
      .pin       (in_item.pin_levels[g]),
      .present   (present_r[g]),
      .high_only (high_only_r[g]),
      .stat      (lane_stat[g])
    );
  end

  eic_merge #(
    .LANES (LANES)
  ) u_merge (
    .stat          (lane_stat),
    .op            (in_item.op),
    .reg_sel       (in_item.reg_sel),
    .present       (present_r[LANES-1:0]),
    .read_data     (merged.read_data),
    .irq_request_n (merged.irq_request_n)
  );

  always_comb begin
    present_nxt   = present_r;
    high_only_nxt = high_only_r;
    if (cfg_we) begin
      unique case (eic_pkg::cfg_idx_t'(cfg_index))
        eic_pkg::CFG_LINE_PRESENT:    present_nxt   = cfg_wdata;
        eic_pkg::CFG_LEVEL_HIGH_ONLY: high_only_nxt = cfg_wdata;
        default: ;
      endcase
    end
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r   <= eic_pkg::PRESENT_RESET;
      high_only_r <= eic_pkg::HIGH_ONLY_RESET;
      out_valid_r <= 1'b0;
    end else begin
      present_r   <= present_nxt;
      high_only_r <= high_only_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_item_r <= merged;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid)
    else $error("accepted item produced no result");

  a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_item.op != eic_pkg::OP_READ) |=> (out_item.read_data == '0))
    else $error("read data nonzero for a non-read item");

  a_clear_all_drops_irq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_item.op == eic_pkg::OP_WRITE && in_item.reg_sel == eic_pkg::SEL_STATUS
     && in_item.write_data == 16'hFFFF) |=> out_item.irq_request_n)
    else $error("request still active after clearing all pending bits");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

// File: rtl/eic_lane.sv
// One interrupt line: detection, pending latch and per-line register bits.
`timescale 1ns / 1ps

module eic_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  eic_pkg::lane_ctrl_t ctrl,
  input  logic               write_bit,
  input  logic               pin,
  input  logic               present,
  input  logic               high_only,
  output eic_pkg::lane_stat_t stat
);

  logic pending_r, pending_nxt;
  logic enable_r, enable_nxt;
  logic polarity_r, polarity_nxt;
  logic edge_r, edge_nxt;
  logic prev_pin_r, prev_pin_nxt;
  logic pol_eff, edge_eff, at_level, changed, hit;

  always_comb begin
    pol_eff  = polarity_r | high_only;
    edge_eff = edge_r & ~high_only;
    at_level = ~(pin ^ pol_eff);
    changed  = pin ^ prev_pin_r;
    hit      = edge_eff ? (changed & at_level) : at_level;

    pending_nxt  = pending_r;
    enable_nxt   = enable_r;
    polarity_nxt = polarity_r;
    edge_nxt     = edge_r;
    prev_pin_nxt = prev_pin_r;
    if (ctrl.tick) begin
      pending_nxt  = pending_r | (hit & present);
      prev_pin_nxt = pin;
    end
    if (ctrl.wr_status) begin
      pending_nxt = pending_r & ~write_bit;
    end
    if (ctrl.wr_mask) begin
      enable_nxt = write_bit & present;
    end
    if (ctrl.wr_polarity) begin
      polarity_nxt = write_bit & present;
    end
    if (ctrl.wr_type) begin
      edge_nxt = write_bit & present;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= 1'b0;
      enable_r   <= 1'b0;
      polarity_r <= 1'b0;
      edge_r     <= 1'b0;
      prev_pin_r <= 1'b0;
    end else begin
      pending_r  <= pending_nxt;
      enable_r   <= enable_nxt;
      polarity_r <= polarity_nxt;
      edge_r     <= edge_nxt;
      prev_pin_r <= prev_pin_nxt;
    end
  end

  assign stat = '{pending:     pending_r,
                  enable:      enable_r,
                  polarity:    polarity_r,
                  edge_mode:   edge_r,
                  pending_nxt: pending_nxt,
                  enable_nxt:  enable_nxt};

endmodule

// File: rtl/eic_merge.sv
// Merge of lane results into read data and the active-low request.
`timescale 1ns / 1ps

module eic_merge #(
  parameter int LANES = 16
) (
  input  eic_pkg::lane_stat_t          stat [LANES],
  input  logic [1:0]                   op,
  input  logic [1:0]                   reg_sel,
  input  logic [LANES-1:0]             present,
  output logic [eic_pkg::WORD_W-1:0]   read_data,
  output logic                         irq_request_n
);

  logic [LANES-1:0] sel_bits;
  logic [LANES-1:0] req_bits;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      unique case (eic_pkg::sel_t'(reg_sel))
        eic_pkg::SEL_STATUS:   sel_bits[i] = stat[i].pending;
        eic_pkg::SEL_MASK:     sel_bits[i] = stat[i].enable;
        eic_pkg::SEL_POLARITY: sel_bits[i] = stat[i].polarity;
        eic_pkg::SEL_TYPE:     sel_bits[i] = stat[i].edge_mode;
        default:               sel_bits[i] = 1'b0;
      endcase
      req_bits[i] = stat[i].pending_nxt & stat[i].enable_nxt & present[i];
    end
    read_data = '0;
    if (eic_pkg::op_t'(op) == eic_pkg::OP_READ) begin
      read_data[LANES-1:0] = sel_bits & present;
    end
    irq_request_n = ~(|req_bits);
  end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the external interrupt controller: table, random items, predictor.
`timescale 1ns / 1ps

module tb_top;
  import eic_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_ITEMS = 200;
  localparam int PHASE_COUNT = 6;

  typedef struct packed {
    logic      chk;
    in_item_t  item;
    out_item_t resp;
  } table_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;
  logic cfg_we;
  logic cfg_index;
  logic [WORD_W-1:0] cfg_wdata;

  external_interrupt_controller uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // predicted controller state
  logic [WORD_W-1:0] pred_present = PRESENT_RESET;
  logic [WORD_W-1:0] pred_high_only = HIGH_ONLY_RESET;
  logic [WORD_W-1:0] pred_pending = '0;
  logic [WORD_W-1:0] pred_enable = '0;
  logic [WORD_W-1:0] pred_polarity = '0;
  logic [WORD_W-1:0] pred_edge = '0;
  logic [WORD_W-1:0] pred_prev_pins = '0;

  out_item_t expected_responses[$];
  int mismatches = 0;
  int cycle_count = 0;
  bit quiet = 1'b0;
  bit hold_request = 1'b0;

  table_row_t directed_rows[23] = '{
    '{1'b1, '{OP_READ,  SEL_STATUS,   16'h0000, 16'h0000}, '{16'h0000, 1'b1}},
    '{1'b1, '{OP_READ,  SEL_MASK,     16'h0000, 16'h0000}, '{16'h0000, 1'b1}},
    '{1'b1, '{OP_READ,  SEL_POLARITY, 16'h0000, 16'h0000}, '{16'h0000, 1'b1}},
    '{1'b1, '{OP_READ,  SEL_TYPE,     16'h0000, 16'h0000}, '{16'h0000, 1'b1}},
    '{1'b1, '{OP_WRITE, SEL_MASK,     16'hFFFF, 16'h0000}, '{16'h0000, 1'b1}},
    '{1'b1, '{OP_READ,  SEL_MASK,     16'h0000, 16'hFFFF}, '{16'hDEF8, 1'b1}},
    '{1'b1, '{OP_TICK,  SEL_STATUS,   16'hFFFF, 16'h0000}, '{16'h0000, 1'b0}},
    '{1'b1, '{OP_READ,  SEL_STATUS,   16'h0000, 16'h0000}, '{16'h0EF8, 1'b0}},
    '{1'b1, '{OP_WRITE, SEL_STATUS,   16'hFFFF, 16'h0000}, '{16'h0000, 1'b1}},
    '{1'b1, '{OP_WRITE, SEL_POLARITY, 16'hFFFF, 16'h0000}, '{16'h0000, 1'b1}},
    '{1'b1, '{OP_TICK,  SEL_MASK,     16'h0000, 16'h0000}, '{16'h0000, 1'b1}},
    '{1'b1, '{OP_WRITE, SEL_TYPE,     16'hFFFF, 16'h0000}, '{16'h0000, 1'b1}},
    '{1'b0, '{OP_TICK,  SEL_STATUS,   16'h0000, 16'hFFFF}, '{16'h0000, 1'b0}},
    '{1'b0, '{OP_READ,  SEL_TYPE,     16'h0000, 16'h0000}, '{16'h0000, 1'b0}},
    '{1'b1, '{OP_WRITE, SEL_STATUS,   16'hFFFF, 16'h0000}, '{16'h0000, 1'b1}},
    '{1'b0, '{OP_TICK,  SEL_STATUS,   16'h0000, 16'hFFFF}, '{16'h0000, 1'b0}},
    '{1'b0, '{OP_WRITE, SEL_STATUS,   16'h0000, 16'hFFFF}, '{16'h0000, 1'b0}},
    '{1'b0, '{OP_NOP,   SEL_TYPE,     16'hFFFF, 16'hFFFF}, '{16'h0000, 1'b0}},
    '{1'b0, '{OP_WRITE, SEL_POLARITY, 16'h0000, 16'hFFFF}, '{16'h0000, 1'b0}},
    '{1'b0, '{OP_TICK,  SEL_POLARITY, 16'h0000, 16'h0000}, '{16'h0000, 1'b0}},
    '{1'b0, '{OP_READ,  SEL_STATUS,   16'hFFFF, 16'hFFFF}, '{16'h0000, 1'b0}},
    '{1'b1, '{OP_WRITE, SEL_MASK,     16'h0000, 16'h0000}, '{16'h0000, 1'b1}},
    '{1'b0, '{OP_READ,  SEL_POLARITY, 16'h0000, 16'h0000}, '{16'h0000, 1'b0}}
  };

  logic [WORD_W-1:0] phase_present[PHASE_COUNT] =
    '{16'hDEF8, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h5A3C, 16'h0000};
  logic [WORD_W-1:0] phase_high_only[PHASE_COUNT] =
    '{16'hD000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0F0F, 16'h0000};

  function automatic out_item_t apply_bus_op(in_item_t it);
    logic [WORD_W-1:0] pol_eff;
    logic [WORD_W-1:0] edge_eff;
    logic [WORD_W-1:0] at_level;
    logic [WORD_W-1:0] changed;
    logic [WORD_W-1:0] rdata;
    out_item_t resp;
    rdata = '0;
    case (it.op)
      OP_TICK: begin
        pol_eff = pred_polarity | pred_high_only;
        edge_eff = pred_edge & ~pred_high_only;
        at_level = ~(it.pin_levels ^ pol_eff);
        changed = it.pin_levels ^ pred_prev_pins;
        pred_pending |= ((edge_eff & changed & at_level) | (~edge_eff & at_level)) & pred_present;
        pred_prev_pins = it.pin_levels;
      end
      OP_READ: begin
        case (it.reg_sel)
          SEL_STATUS:   rdata = pred_pending;
          SEL_MASK:     rdata = pred_enable;
          SEL_POLARITY: rdata = pred_polarity;
          default:      rdata = pred_edge;
        endcase
        rdata &= pred_present;
      end
      OP_WRITE: begin
        case (it.reg_sel)
          SEL_STATUS:   pred_pending &= ~it.write_data;
          SEL_MASK:     pred_enable = it.write_data & pred_present;
          SEL_POLARITY: pred_polarity = it.write_data & pred_present;
          default:      pred_edge = it.write_data & pred_present;
        endcase
      end
      default: ;
    endcase
    resp.read_data = rdata;
    resp.irq_request_n = ((pred_pending & pred_enable & pred_present) == '0);
    return resp;
  endfunction

  function automatic in_item_t random_bus_op();
    in_item_t it;
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) it.op = OP_TICK;
    else if (pick < 70) it.op = OP_READ;
    else if (pick < 95) it.op = OP_WRITE;
    else it.op = OP_NOP;
    it.reg_sel = 2'($urandom_range(3));
    case ($urandom_range(9))
      0: it.write_data = '0;
      1: it.write_data = '1;
      2, 3, 4: it.write_data = WORD_W'(1) << $urandom_range(WORD_W - 1);
      default: it.write_data = WORD_W'($urandom);
    endcase
    case ($urandom_range(9))
      0: it.pin_levels = '0;
      1: it.pin_levels = '1;
      2, 3, 4, 5: it.pin_levels = pred_prev_pins ^ (WORD_W'(1) << $urandom_range(WORD_W - 1));
      default: it.pin_levels = WORD_W'($urandom);
    endcase
    return it;
  endfunction

  task automatic send_item(in_item_t it, bit chk, out_item_t typed);
    out_item_t predicted;
    @(negedge clk);
    while (!quiet && !hold_request && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    predicted = apply_bus_op(it);
    expected_responses.push_back(chk ? typed : predicted);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_responses.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [WORD_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LINE_PRESENT) pred_present = value;
    else pred_high_only = value;
  endtask

  task automatic note_mismatch(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s at %0t: expected %h, got %h", field, $realtime, want, got);
  endtask

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item at %0t: %h", $realtime, out_item);
      end else begin
        want = expected_responses.pop_front();
        if (out_item.read_data !== want.read_data)
          note_mismatch("read_data", want.read_data, out_item.read_data);
        if (out_item.irq_request_n !== want.irq_request_n)
          note_mismatch("irq_request_n", WORD_W'(want.irq_request_n),
                        WORD_W'(out_item.irq_request_n));
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 12);
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_LINE_PRESENT;
    cfg_wdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].chk, directed_rows[i].resp);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_for_results();
      write_cfg(CFG_LINE_PRESENT, phase_present[p]);
      write_cfg(CFG_LEVEL_HIGH_ONLY, phase_high_only[p]);
      quiet = (p == 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 3 && i == 50) hold_request = 1'b1;
        if (p == 4 && i == 100) wait_for_results();
        send_item(random_bus_op(), 1'b0, '0);
      end
    end
    quiet = 1'b0;

    wait_for_results();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && expected_responses.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
